>>> hdl/png_unfilter_rgba_expand_assert.svh
// Assertion macros for the PNG unfilter block.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef PNG_UNFILTER_RGBA_EXPAND_ASSERT_SVH
`define PNG_UNFILTER_RGBA_EXPAND_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define PU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PU_ASSERT_IMP(lbl, ante, cons)
`define PU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/pngunf_pkg.sv
// Shared types and constants for the PNG unfilter and RGBA expander.
// No dependencies.
`default_nettype none
package pngunf_pkg;

    localparam int MAX_WIDTH_DEF     = 2048;
    localparam int PALETTE_DEPTH_DEF = 256;

    localparam logic [2:0] REG_COLOR_MODE   = 3'd0;
    localparam logic [2:0] REG_ROW_WIDTH    = 3'd1;
    localparam logic [2:0] REG_ROW_COUNT    = 3'd2;
    localparam logic [2:0] REG_KEY_COUNT    = 3'd3;
    localparam logic [2:0] REG_KEY_RED      = 3'd4;
    localparam logic [2:0] REG_KEY_GREEN    = 3'd5;
    localparam logic [2:0] REG_KEY_BLUE     = 3'd6;
    localparam logic [2:0] REG_PALETTE_SIZE = 3'd7;

    localparam logic [2:0] MODE_GREY  = 3'd0;
    localparam logic [2:0] MODE_RGB   = 3'd1;
    localparam logic [2:0] MODE_PAL   = 3'd2;
    localparam logic [2:0] MODE_GREYA = 3'd3;
    localparam logic [2:0] MODE_RGBA  = 3'd4;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic       OP_STREAM  = 1'b0;
    localparam logic       OP_PALETTE = 1'b1;

    typedef enum logic [1:0] {
        KIND_FILT,
        KIND_BYTE,
        KIND_ERR
    } kind_t;

    typedef struct packed {
        logic [2:0]  color_mode;
        logic [11:0] row_width;
        logic [15:0] row_count;
        logic [8:0]  key_count;
        logic [15:0] key_red;
        logic [15:0] key_green;
        logic [15:0] key_blue;
        logic [8:0]  palette_size;
    } cfg_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] stream_byte;
        logic [7:0] entry_index;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
        logic [7:0] entry_alpha;
    } in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } out_t;

endpackage
`default_nettype wire

>>> hdl/png_unfilter_rgba_expand.sv
// Top level: PNG scanline unfilter with prior-row memory, palette memory and RGBA expansion.
// Depends on pngunf_pkg, pngunf_regs and png_unfilter_rgba_expand_assert.svh.
//
//  channel  | direction | handshake           | payload
//  src      | in        | src_valid/src_stall | pngunf_pkg::in_t  src_data
//  pix      | out       | pix_valid/pix_stall | pngunf_pkg::out_t pix_data
//  apb      | in/out    | psel/penable/pready | paddr, pwdata, prdata
//
// One beat per cycle while pix_stall is low; pix_valid is set in the output register as a
// pixel's last byte leaves the middle stage. Prior row: read at accept, written at that exit.
// Reset clears control state; both memories hold garbage until written.
// pix_stall holds a valid output register and a full middle stage; src_stall rises with them.
`default_nettype none
`include "png_unfilter_rgba_expand_assert.svh"
module png_unfilter_rgba_expand
#(
    parameter int MAX_WIDTH     = pngunf_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_DEPTH = pngunf_pkg::PALETTE_DEPTH_DEF
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [4:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire                src_valid,
    output logic               src_stall,
    input  pngunf_pkg::in_t    src_data,
    output logic               pix_valid,
    input  wire                pix_stall,
    output pngunf_pkg::out_t   pix_data
);

    localparam int ROW_BYTES = MAX_WIDTH * 4;
    localparam int AW        = $clog2(ROW_BYTES);
    localparam int CW        = $clog2(ROW_BYTES + 1);
    localparam int PW        = $clog2(PALETTE_DEPTH);
    localparam logic [CW:0] ROW_BYTES_C = (CW+1)'(ROW_BYTES);
    localparam logic [8:0]  PAL_DEPTH_C = 9'(PALETTE_DEPTH);

    pngunf_pkg::cfg_t cfg;

    pngunf_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // memories
    logic [7:0]  row_mem [ROW_BYTES];
    logic [31:0] pal_mem [PALETTE_DEPTH];

    // front control state
    logic [CW-1:0] col_reg, col_next;
    logic [1:0]    m3_reg, m3_next;
    logic [15:0]   rnum_reg, rnum_next;
    logic [2:0]    filt_reg, filt_next;
    logic          err_reg, err_next;

    // middle stage
    logic                s1_vld_reg, s1_vld_next;
    pngunf_pkg::kind_t   s1_kind_reg;
    logic [2:0]          s1_filt_reg;
    logic [1:0]          s1_k_reg;
    logic                s1_last_reg, s1_rend_reg, s1_iend_reg;
    logic                s1_wr_reg, s1_prior_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [7:0]          s1_x_reg;
    logic [7:0]          row_q_reg;
    logic [3:0][7:0]     left_reg, ul_reg, gath_reg;

    // output stage
    logic        o_vld_reg;
    logic [31:0] o_px_reg;
    logic        o_rend_reg, o_iend_reg, o_bad_reg, o_palok_reg;
    logic [31:0] o_pal_reg;

    logic          adv2, acc, acc_stream;
    logic [2:0]    bpp;
    logic [1:0]    k;
    logic [CW-1:0] width_w, rowsize, col_m1;
    logic [15:0]   rows;
    logic          last, row_done, img_done, in_buf, s1_entry;
    pngunf_pkg::kind_t kind_in;

    assign adv2       = !o_vld_reg || !pix_stall;
    assign src_stall  = s1_vld_reg && !adv2;
    assign acc        = src_valid && !src_stall;
    assign acc_stream = acc && (src_data.operation == pngunf_pkg::OP_STREAM) && !err_reg;

    always_comb
    begin
        case (cfg.color_mode)
            pngunf_pkg::MODE_RGB:   bpp = 3'd3;
            pngunf_pkg::MODE_GREYA: bpp = 3'd2;
            pngunf_pkg::MODE_RGBA:  bpp = 3'd4;
            default:                bpp = 3'd1;
        endcase
    end

    always_comb
    begin
        if (cfg.row_width == 12'd0)
            width_w = CW'(1);
        else if (32'(cfg.row_width) > 32'(MAX_WIDTH))
            width_w = CW'(MAX_WIDTH);
        else
            width_w = CW'(cfg.row_width);
    end

    assign rowsize  = CW'(width_w * CW'(bpp));
    assign rows     = (cfg.row_count == 16'd0) ? 16'd1 : cfg.row_count;
    assign col_m1   = col_reg - CW'(1);

    // byte lane within the pixel, from the column or m3_reg, so a mode change applies at once
    always_comb
    begin
        case (bpp)
            3'd3:    k = m3_reg;
            3'd2:    k = {1'b0, col_m1[0]};
            3'd4:    k = col_m1[1:0];
            default: k = 2'd0;
        endcase
    end

    assign in_buf   = {1'b0, col_reg} <= ROW_BYTES_C;
    assign last     = {1'b0, k} == (bpp - 3'd1);
    assign row_done = last && (col_reg >= rowsize);
    assign img_done = row_done && (({1'b0, rnum_reg} + 17'd1) >= {1'b0, rows});

    // front control: column, column modulo three, row number, filter type and error flag
    always_comb
    begin
        col_next  = col_reg;
        m3_next   = m3_reg;
        rnum_next = rnum_reg;
        filt_next = filt_reg;
        err_next  = err_reg;
        kind_in   = pngunf_pkg::KIND_BYTE;
        s1_entry  = acc_stream;
        if (acc_stream)
        begin
            if (col_reg == '0)
            begin
                if (src_data.stream_byte > 8'd4)
                begin
                    err_next = 1'b1;
                    kind_in  = pngunf_pkg::KIND_ERR;
                end
                else
                begin
                    filt_next = src_data.stream_byte[2:0];
                    col_next  = CW'(1);
                    m3_next   = 2'd0;
                    kind_in   = pngunf_pkg::KIND_FILT;
                end
            end
            else
            begin
                col_next = row_done ? '0 : col_reg + CW'(1);
                m3_next  = (m3_reg == 2'd2) ? 2'd0 : m3_reg + 2'd1;
                if (row_done)
                    rnum_next = img_done ? 16'd0 : rnum_reg + 16'd1;
            end
        end
    end

    always_comb
    begin
        if (acc)
            s1_vld_next = s1_entry;
        else if (adv2)
            s1_vld_next = 1'b0;
        else
            s1_vld_next = s1_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            m3_reg     <= 2'd0;
            rnum_reg   <= 16'd0;
            filt_reg   <= pngunf_pkg::FILT_NONE;
            err_reg    <= 1'b0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            m3_reg     <= m3_next;
            rnum_reg   <= rnum_next;
            filt_reg   <= filt_next;
            err_reg    <= err_next;
            s1_vld_reg <= s1_vld_next;
        end
    end

    // middle stage payload and prior-row read
    always_ff @(posedge clk)
    begin
        if (acc_stream)
        begin
            s1_kind_reg  <= kind_in;
            s1_filt_reg  <= filt_reg;
            s1_k_reg     <= k;
            s1_last_reg  <= last;
            s1_rend_reg  <= row_done;
            s1_iend_reg  <= img_done;
            s1_wr_reg    <= in_buf;
            s1_prior_reg <= (rnum_reg != 16'd0) && in_buf;
            s1_addr_reg  <= col_m1[AW-1:0];
            s1_x_reg     <= src_data.stream_byte;
            row_q_reg    <= row_mem[col_m1[AW-1:0]];
        end
    end

    // reconstruction
    logic [7:0]  fa, fb, fc, pred, v;
    logic [8:0]  sum_ab, pa, pb, pc;
    logic [9:0]  p2;
    logic [3:0][7:0] gath_new;
    logic        mid_go, mid_byte, mid_res;
    logic [7:0]  pal_idx;

    assign fa     = left_reg[s1_k_reg];
    assign fc     = ul_reg[s1_k_reg];
    assign fb     = s1_prior_reg ? row_q_reg : 8'd0;
    assign sum_ab = {1'b0, fa} + {1'b0, fb};

    // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    always_comb
    begin
        pa = (fb >= fc) ? 9'(fb - fc) : 9'(fc - fb);
        pb = (fa >= fc) ? 9'(fa - fc) : 9'(fc - fa);
        p2 = {1'b0, sum_ab} - {1'b0, fc, 1'b0};
        pc = p2[9] ? 9'(-p2) : p2[8:0];
    end

    always_comb
    begin
        case (s1_filt_reg)
            pngunf_pkg::FILT_SUB:   pred = fa;
            pngunf_pkg::FILT_UP:    pred = fb;
            pngunf_pkg::FILT_AVG:   pred = sum_ab[8:1];
            pngunf_pkg::FILT_PAETH:
            begin
                if (pa <= pb && pa <= pc)
                    pred = fa;
                else if (pb <= pc)
                    pred = fb;
                else
                    pred = fc;
            end
            default:                pred = 8'd0;
        endcase
    end

    assign v        = s1_x_reg + pred;
    assign mid_go   = s1_vld_reg && adv2;
    assign mid_byte = mid_go && (s1_kind_reg == pngunf_pkg::KIND_BYTE);
    assign mid_res  = (mid_byte && s1_last_reg) ||
                      (mid_go && (s1_kind_reg == pngunf_pkg::KIND_ERR));

    always_comb
    begin
        gath_new           = gath_reg;
        gath_new[s1_k_reg] = v;
    end

    assign pal_idx = gath_new[0];

    always_ff @(posedge clk)
    begin
        if (mid_byte && s1_wr_reg)
            row_mem[s1_addr_reg] <= v;
        if (mid_go && s1_kind_reg == pngunf_pkg::KIND_FILT)
        begin
            left_reg <= '0;
            ul_reg   <= '0;
            gath_reg <= '0;
        end
        else if (mid_byte)
        begin
            left_reg[s1_k_reg] <= v;
            ul_reg[s1_k_reg]   <= fb;
            gath_reg           <= s1_last_reg ? '0 : gath_new;
        end
    end

    // palette: written at accept, read as the pixel leaves the middle stage
    always_ff @(posedge clk)
    begin
        if (acc && src_data.operation == pngunf_pkg::OP_PALETTE &&
            {1'b0, src_data.entry_index} < PAL_DEPTH_C)
            pal_mem[src_data.entry_index[PW-1:0]] <= {src_data.entry_alpha,
                src_data.entry_blue, src_data.entry_green, src_data.entry_red};
        if (mid_res)
            o_pal_reg <= pal_mem[pal_idx[PW-1:0]];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else if (adv2)
            o_vld_reg <= mid_res;
    end

    always_ff @(posedge clk)
    begin
        if (mid_res)
        begin
            if (s1_kind_reg == pngunf_pkg::KIND_ERR)
            begin
                o_px_reg   <= '0;
                o_rend_reg <= 1'b0;
                o_iend_reg <= 1'b0;
                o_bad_reg  <= 1'b1;
            end
            else
            begin
                o_px_reg   <= gath_new;
                o_rend_reg <= s1_rend_reg;
                o_iend_reg <= s1_iend_reg;
                o_bad_reg  <= 1'b0;
            end
            o_palok_reg <= ({1'b0, pal_idx} < cfg.palette_size) &&
                           ({1'b0, pal_idx} < PAL_DEPTH_C);
        end
    end

    // RGBA expansion
    logic [7:0] s0, s1b, s2, s3;
    logic       key_on;

    assign s0     = o_px_reg[7:0];
    assign s1b    = o_px_reg[15:8];
    assign s2     = o_px_reg[23:16];
    assign s3     = o_px_reg[31:24];
    assign key_on = cfg.key_count != 9'd0;

    always_comb
    begin
        pix_data = '0;
        if (!o_bad_reg)
        begin
            case (cfg.color_mode)
                pngunf_pkg::MODE_RGB:
                begin
                    pix_data.red   = s0;
                    pix_data.green = s1b;
                    pix_data.blue  = s2;
                    pix_data.alpha = (key_on && cfg.key_red == {8'd0, s0} &&
                                      cfg.key_green == {8'd0, s1b} &&
                                      cfg.key_blue == {8'd0, s2}) ? 8'h00 : 8'hFF;
                end
                pngunf_pkg::MODE_PAL:
                begin
                    if (o_palok_reg)
                    begin
                        pix_data.red   = o_pal_reg[7:0];
                        pix_data.green = o_pal_reg[15:8];
                        pix_data.blue  = o_pal_reg[23:16];
                        pix_data.alpha = o_pal_reg[31:24];
                    end
                    else
                    begin
                        pix_data.alpha = 8'hFF;
                    end
                end
                pngunf_pkg::MODE_GREYA:
                begin
                    pix_data.red   = s0;
                    pix_data.green = s0;
                    pix_data.blue  = s0;
                    pix_data.alpha = s1b;
                end
                pngunf_pkg::MODE_RGBA:
                begin
                    pix_data.red   = s0;
                    pix_data.green = s1b;
                    pix_data.blue  = s2;
                    pix_data.alpha = s3;
                end
                default:
                begin
                    pix_data.red   = s0;
                    pix_data.green = s0;
                    pix_data.blue  = s0;
                    pix_data.alpha = (key_on && cfg.key_red == {8'd0, s0}) ? 8'h00 : 8'hFF;
                end
            endcase
            pix_data.row_end   = o_rend_reg;
            pix_data.image_end = o_iend_reg;
        end
        pix_data.bad_filter = o_bad_reg;
    end

    assign pix_valid = o_vld_reg;

    `PU_ASSERT_NXT(a_err_sticks, err_reg, err_reg)
    `PU_ASSERT_IMP(a_err_col_idle, err_reg, col_reg == '0)
    `PU_ASSERT_NXT(a_mid_holds, s1_vld_reg && !adv2, s1_vld_reg)
    `PU_ASSERT_IMP(a_bad_blank, o_vld_reg && o_bad_reg,
                   pix_data.red == 8'd0 && pix_data.alpha == 8'd0 && !pix_data.row_end)

endmodule
`default_nettype wire

>>> hdl/pngunf_regs.sv
// APB register file for the PNG unfilter block.
// Depends on pngunf_pkg for the register indexes and cfg_t.
`default_nettype none
module pngunf_regs
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [4:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output pngunf_pkg::cfg_t  cfg
);

    pngunf_pkg::cfg_t cfg_reg;
    pngunf_pkg::cfg_t cfg_next;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (paddr[4:2])
                pngunf_pkg::REG_COLOR_MODE:   cfg_next.color_mode   = pwdata[2:0];
                pngunf_pkg::REG_ROW_WIDTH:    cfg_next.row_width    = pwdata[11:0];
                pngunf_pkg::REG_ROW_COUNT:    cfg_next.row_count    = pwdata[15:0];
                pngunf_pkg::REG_KEY_COUNT:    cfg_next.key_count    = pwdata[8:0];
                pngunf_pkg::REG_KEY_RED:      cfg_next.key_red      = pwdata[15:0];
                pngunf_pkg::REG_KEY_GREEN:    cfg_next.key_green    = pwdata[15:0];
                pngunf_pkg::REG_KEY_BLUE:     cfg_next.key_blue     = pwdata[15:0];
                pngunf_pkg::REG_PALETTE_SIZE: cfg_next.palette_size = pwdata[8:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            pngunf_pkg::REG_COLOR_MODE:   prdata = {29'd0, cfg_reg.color_mode};
            pngunf_pkg::REG_ROW_WIDTH:    prdata = {20'd0, cfg_reg.row_width};
            pngunf_pkg::REG_ROW_COUNT:    prdata = {16'd0, cfg_reg.row_count};
            pngunf_pkg::REG_KEY_COUNT:    prdata = {23'd0, cfg_reg.key_count};
            pngunf_pkg::REG_KEY_RED:      prdata = {16'd0, cfg_reg.key_red};
            pngunf_pkg::REG_KEY_GREEN:    prdata = {16'd0, cfg_reg.key_green};
            pngunf_pkg::REG_KEY_BLUE:     prdata = {16'd0, cfg_reg.key_blue};
            pngunf_pkg::REG_PALETTE_SIZE: prdata = {23'd0, cfg_reg.palette_size};
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= pngunf_pkg::cfg_t'{3'd0, 12'd1, 16'd1, 9'd0,
                                          16'd0, 16'd0, 16'd0, 9'd0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire
